FILE: rtl/lob_pkg.sv
// Package for the limit order book matcher.
// Holds codes, the scan token, scan parameters and the slot write request.
// No dependencies.
package lob_pkg;

  localparam int unsigned SLOT_IW = 6;
  localparam int unsigned AVAIL_W = 39;

  typedef enum logic [1:0] {
    ACT_SUBMIT = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_MODIFY = 2'd2,
    ACT_ADD    = 2'd3
  } action_e;

  localparam logic [2:0] TYPE_MARKET     = 3'd0;
  localparam logic [2:0] TYPE_FOK        = 3'd3;
  localparam logic [2:0] TYPE_IOC        = 3'd2;
  localparam logic [2:0] TYPE_STOP_LIMIT = 3'd5;

  typedef enum logic [2:0] {
    OC_RESTED        = 3'd0,
    OC_FILLED        = 3'd1,
    OC_REM_CANCELLED = 3'd2,
    OC_FOK_KILLED    = 3'd3,
    OC_CANCELLED     = 3'd4,
    OC_NOT_FOUND     = 3'd5,
    OC_MODIFIED      = 3'd6,
    OC_BOOK_FULL     = 3'd7
  } outcome_e;

  typedef enum logic [1:0] {
    WR_CLEAR  = 2'd0,
    WR_NEW    = 2'd1,
    WR_FILL   = 2'd2,
    WR_MODIFY = 2'd3
  } wr_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_MATCH = 2'd1,
    PH_FINAL = 2'd2
  } phase_e;

  typedef struct packed {
    logic               m_found;
    logic [SLOT_IW-1:0] m_idx;
    logic [31:0]        m_price;
    logic [31:0]        m_age;
    logic [31:0]        m_rem;
    logic [31:0]        m_id;
    logic               bid_any;
    logic [31:0]        bid;
    logic               ask_any;
    logic [31:0]        ask;
    logic               id_found;
    logic [SLOT_IW-1:0] id_idx;
    logic               free_found;
    logic [SLOT_IW-1:0] free_idx;
    logic [AVAIL_W-1:0] avail;
  } tok_t;

  typedef struct packed {
    logic        rs;
    logic        use_lim;
    logic [31:0] limit;
    logic [31:0] id;
    logic [31:0] now;
  } scan_t;

  typedef struct packed {
    logic               en;
    wr_op_e             op;
    logic [SLOT_IW-1:0] idx;
    logic [31:0]        id;
    logic               side;
    logic [31:0]        price;
    logic [31:0]        rem;
    logic [31:0]        arr;
  } cmd_t;

endpackage

FILE: rtl/lob_cell.sv
// One book slot of the cell chain: holds an entry and folds it into the scan token.
// Depends on lob_pkg.
module lob_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [lob_pkg::SLOT_IW-1:0] idx_i,
  input  lob_pkg::scan_t              scan_i,
  input  lob_pkg::cmd_t               cmd_i,
  input  lob_pkg::tok_t               tok_i,
  output lob_pkg::tok_t               tok_o
);
  import lob_pkg::*;

  logic        valid_q, valid_d;
  logic [31:0] id_q, price_q, rem_q, arr_q;
  logic        side_q;
  logic [31:0] age;
  logic        on_side, in_lim, hit, better;
  tok_t        tok_d;

  always_comb begin
    age     = scan_i.now - arr_q;
    on_side = valid_q && (side_q == scan_i.rs);
    in_lim  = scan_i.rs ? (price_q <= scan_i.limit) : (price_q >= scan_i.limit);
    hit     = on_side && (!scan_i.use_lim || in_lim);
    if (!tok_i.m_found) begin
      better = 1'b1;
    end else if (price_q != tok_i.m_price) begin
      better = scan_i.rs ? (price_q < tok_i.m_price) : (price_q > tok_i.m_price);
    end else begin
      better = age > tok_i.m_age;
    end
    tok_d = tok_i;
    if (hit && better) begin
      tok_d.m_found = 1'b1;
      tok_d.m_idx   = idx_i;
      tok_d.m_price = price_q;
      tok_d.m_age   = age;
      tok_d.m_rem   = rem_q;
      tok_d.m_id    = id_q;
    end
    if (valid_q && !side_q && (!tok_i.bid_any || price_q > tok_i.bid)) begin
      tok_d.bid_any = 1'b1;
      tok_d.bid     = price_q;
    end
    if (valid_q && side_q && (!tok_i.ask_any || price_q < tok_i.ask)) begin
      tok_d.ask_any = 1'b1;
      tok_d.ask     = price_q;
    end
    if (!tok_i.id_found && valid_q && id_q == scan_i.id) begin
      tok_d.id_found = 1'b1;
      tok_d.id_idx   = idx_i;
    end
    if (!tok_i.free_found && !valid_q) begin
      tok_d.free_found = 1'b1;
      tok_d.free_idx   = idx_i;
    end
    if (on_side && in_lim) begin
      tok_d.avail = tok_i.avail + AVAIL_W'(rem_q);
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (cmd_i.en && cmd_i.idx == idx_i) begin
      unique case (cmd_i.op)
        WR_CLEAR:  valid_d = 1'b0;
        WR_NEW:    valid_d = 1'b1;
        WR_FILL:   valid_d = (cmd_i.rem != '0);
        WR_MODIFY: valid_d = valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_o <= tok_d;
    if (cmd_i.en && cmd_i.idx == idx_i) begin
      unique case (cmd_i.op)
        WR_CLEAR: begin
        end
        WR_NEW: begin
          id_q    <= cmd_i.id;
          side_q  <= cmd_i.side;
          price_q <= cmd_i.price;
          rem_q   <= cmd_i.rem;
          arr_q   <= cmd_i.arr;
        end
        WR_FILL: begin
          rem_q <= cmd_i.rem;
        end
        WR_MODIFY: begin
          price_q <= cmd_i.price;
          rem_q   <= cmd_i.rem;
          arr_q   <= cmd_i.arr;
        end
      endcase
    end
  end

endmodule

FILE: rtl/limit_order_book_matcher_unit.sv
// Top level of the price-time priority limit order book matcher.
// Depends on lob_pkg and lob_cell (one per book slot).
//
// Each book access is a scan: a token walks the chain of MAX_ORDERS slot cells, one
// cell per cycle, and returns the best match, best bid and ask, the slot of an order
// id, the first free slot and the quantity available within a limit. Cancel, modify
// and add take two scans (one when nothing changes); a submit takes one scan per fill
// plus one, and one more when it rests.
// Results come out on result_valid_o for one cycle each and cannot be stalled;
// the next request is taken when busy is low.
module limit_order_book_matcher_unit #(
  parameter int unsigned MAX_ORDERS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action_i,
  input  logic [31:0] order_id_i,
  input  logic        side_i,
  input  logic [2:0]  order_type_i,
  input  logic [31:0] price_i,
  input  logic [31:0] quantity_i,
  output logic        result_valid_o,
  output logic        trade_valid_o,
  output logic [31:0] buy_order_id_o,
  output logic [31:0] sell_order_id_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] trade_quantity_o,
  output logic [31:0] remaining_quantity_o,
  output logic [2:0]  outcome_o,
  output logic [31:0] best_bid_o,
  output logic [31:0] best_ask_o,
  output logic        last_o
);
  import lob_pkg::*;

  localparam int unsigned CW = $clog2(MAX_ORDERS + 1);

  typedef struct packed {
    logic   rescan;
    logic   finish;
    phase_e ph_next;
  } dec_t;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [31:0] ctr_q, ctr_d;
  logic        rv_q;
  logic        pend_vq, pend_vd;

  action_e     act_q;
  logic [31:0] id_q, price_q, qty_q;
  logic        side_q;
  logic [2:0]  type_q;
  logic [31:0] rem_q, rem_d;
  outcome_e    outc_q, outc_d;
  logic [31:0] pend_id_q, pend_id_d, pend_price_q, pend_price_d, pend_qty_q, pend_qty_d;

  logic        accept, done_scan, match_step, emit, em_trade, em_last;
  outcome_e    em_outc;
  logic [31:0] fill;
  dec_t        dec;
  scan_t       scan;
  cmd_t        cmd;
  tok_t        tok [MAX_ORDERS+1];
  tok_t        t;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign done_scan = (state_q == ST_SCAN) && (cnt_q == '0);
  assign t         = tok[MAX_ORDERS];
  assign tok[0]    = '0;

  assign scan.rs      = ~side_q;
  assign scan.use_lim = (type_q != TYPE_MARKET);
  assign scan.limit   = price_q;
  assign scan.id      = id_q;
  assign scan.now     = ctr_q;

  for (genvar i = 0; i < MAX_ORDERS; i++) begin : g_cell
    lob_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SLOT_IW'(i)),
      .scan_i (scan),
      .cmd_i  (cmd),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

  // decisions taken when a request is accepted and when a scan completes
  always_comb begin
    fill = (rem_q < t.m_rem) ? rem_q : t.m_rem;
    cmd        = '0;
    cmd.id     = id_q;
    cmd.side   = side_q;
    cmd.price  = price_q;
    cmd.arr    = ctr_q;
    emit       = 1'b0;
    em_trade   = pend_vq;
    em_last    = 1'b0;
    em_outc    = outc_q;
    match_step = 1'b0;
    dec        = '{rescan: 1'b0, finish: 1'b0, ph_next: PH_FINAL};
    rem_d        = rem_q;
    outc_d       = outc_q;
    ctr_d        = ctr_q;
    pend_vd      = pend_vq;
    pend_id_d    = pend_id_q;
    pend_price_d = pend_price_q;
    pend_qty_d   = pend_qty_q;
    if (accept) begin
      rem_d   = (action_i == ACT_SUBMIT || action_i == ACT_ADD) ? quantity_i : '0;
      outc_d  = OC_FILLED;
      pend_vd = 1'b0;
    end else if (done_scan) begin
      unique case (phase_q)
        PH_FIRST: begin
          unique case (act_q)
            ACT_CANCEL: begin
              if (t.id_found) begin
                cmd.en     = 1'b1;
                cmd.op     = WR_CLEAR;
                cmd.idx    = t.id_idx;
                outc_d     = OC_CANCELLED;
                dec.rescan = 1'b1;
              end else begin
                emit = 1'b1; em_last = 1'b1; em_outc = OC_NOT_FOUND; dec.finish = 1'b1;
              end
            end
            ACT_MODIFY: begin
              if (!t.id_found) begin
                emit = 1'b1; em_last = 1'b1; em_outc = OC_NOT_FOUND; dec.finish = 1'b1;
              end else if (qty_q == '0) begin
                cmd.en     = 1'b1;
                cmd.op     = WR_CLEAR;
                cmd.idx    = t.id_idx;
                outc_d     = OC_CANCELLED;
                dec.rescan = 1'b1;
              end else begin
                cmd.en     = 1'b1;
                cmd.op     = WR_MODIFY;
                cmd.idx    = t.id_idx;
                cmd.rem    = qty_q;
                ctr_d      = ctr_q + 32'd1;
                outc_d     = OC_MODIFIED;
                dec.rescan = 1'b1;
              end
            end
            ACT_ADD: begin
              if (qty_q == '0) begin
                emit = 1'b1; em_last = 1'b1; em_outc = OC_FILLED; dec.finish = 1'b1;
              end else if (t.free_found) begin
                cmd.en     = 1'b1;
                cmd.op     = WR_NEW;
                cmd.idx    = t.free_idx;
                cmd.rem    = qty_q;
                ctr_d      = ctr_q + 32'd1;
                outc_d     = OC_RESTED;
                dec.rescan = 1'b1;
              end else begin
                emit = 1'b1; em_last = 1'b1; em_outc = OC_BOOK_FULL; dec.finish = 1'b1;
              end
            end
            ACT_SUBMIT: begin
              if (type_q > TYPE_STOP_LIMIT) begin
                emit = 1'b1; em_last = 1'b1; em_outc = OC_REM_CANCELLED; dec.finish = 1'b1;
              end else if (type_q == TYPE_FOK && t.avail < AVAIL_W'(qty_q)) begin
                emit = 1'b1; em_last = 1'b1; em_outc = OC_FOK_KILLED; dec.finish = 1'b1;
              end else begin
                match_step = 1'b1;
              end
            end
          endcase
        end
        PH_MATCH: match_step = 1'b1;
        default: begin
          emit = 1'b1; em_last = 1'b1; em_outc = outc_q; dec.finish = 1'b1;
        end
      endcase
      if (match_step) begin
        if (rem_q != '0 && t.m_found) begin
          if (pend_vq) begin
            emit = 1'b1; em_outc = OC_FILLED;
          end
          pend_vd      = 1'b1;
          pend_id_d    = t.m_id;
          pend_price_d = t.m_price;
          pend_qty_d   = fill;
          rem_d        = rem_q - fill;
          cmd.en       = 1'b1;
          cmd.op       = WR_FILL;
          cmd.idx      = t.m_idx;
          cmd.rem      = t.m_rem - fill;
          dec.rescan   = 1'b1;
          dec.ph_next  = PH_MATCH;
        end else if (rem_q == '0) begin
          emit = 1'b1; em_last = 1'b1; em_outc = OC_FILLED; dec.finish = 1'b1;
        end else if (type_q == TYPE_MARKET || type_q == TYPE_IOC || type_q == TYPE_FOK) begin
          emit = 1'b1; em_last = 1'b1; em_outc = OC_REM_CANCELLED; dec.finish = 1'b1;
        end else if (t.free_found) begin
          cmd.en     = 1'b1;
          cmd.op     = WR_NEW;
          cmd.idx    = t.free_idx;
          cmd.rem    = rem_q;
          ctr_d      = ctr_q + 32'd1;
          outc_d     = OC_RESTED;
          dec.rescan = 1'b1;
        end else begin
          emit = 1'b1; em_last = 1'b1; em_outc = OC_BOOK_FULL; dec.finish = 1'b1;
        end
      end
    end
  end

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_SCAN;
          phase_d = PH_FIRST;
          cnt_d   = CW'(MAX_ORDERS);
        end
      end
      ST_SCAN: begin
        if (cnt_q != '0) begin
          cnt_d = cnt_q - CW'(1);
        end else if (dec.rescan) begin
          phase_d = dec.ph_next;
          cnt_d   = CW'(MAX_ORDERS);
        end else if (dec.finish) begin
          state_d = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      phase_q <= PH_FIRST;
      cnt_q   <= '0;
      ctr_q   <= '0;
      rv_q    <= 1'b0;
      pend_vq <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      ctr_q   <= ctr_d;
      rv_q    <= emit;
      pend_vq <= pend_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q   <= action_e'(action_i);
      id_q    <= order_id_i;
      side_q  <= side_i;
      type_q  <= order_type_i;
      price_q <= price_i;
      qty_q   <= quantity_i;
    end
    rem_q        <= rem_d;
    outc_q       <= outc_d;
    pend_id_q    <= pend_id_d;
    pend_price_q <= pend_price_d;
    pend_qty_q   <= pend_qty_d;
    if (emit) begin
      trade_valid_o        <= em_trade;
      buy_order_id_o       <= em_trade ? (side_q ? pend_id_q : id_q) : '0;
      sell_order_id_o      <= em_trade ? (side_q ? id_q : pend_id_q) : '0;
      trade_price_o        <= em_trade ? pend_price_q : '0;
      trade_quantity_o     <= em_trade ? pend_qty_q : '0;
      remaining_quantity_o <= rem_q;
      outcome_o            <= em_outc;
      best_bid_o           <= t.bid_any ? t.bid : '0;
      best_ask_o           <= t.ask_any ? t.ask : '0;
      last_o               <= em_last;
    end
  end

  assign result_valid_o = rv_q;

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy) else $error("intermediate result while idle");
  a_notrade_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !trade_valid_o |-> last_o) else $error("non-trade result not last");
  a_trade_qty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && trade_valid_o |-> trade_quantity_o != '0)
    else $error("trade with zero quantity");
  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !result_valid_o) else $error("request not taken");

endmodule
